@@ sv/olrp_pkg.sv @@
// Shared widths, constants, register codes and reciprocal tables for the rx power block.
`default_nettype none
package olrp_pkg;

  localparam int unsigned DIFF_W     = 26;
  localparam int unsigned SQ_W       = 52;
  localparam int unsigned SUM_W      = 54;
  localparam int unsigned S_W        = 50;
  localparam int unsigned D_W        = 25;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned AREA_W     = 20;
  localparam int unsigned OMC_W      = 16;
  localparam int unsigned M1_W       = 66;
  localparam int unsigned PP_W       = 65;
  localparam int unsigned FULL_W     = 98;
  localparam int unsigned GEO_W      = 62;
  localparam int unsigned DEN_W      = 62;
  localparam int unsigned E_W        = 21;
  localparam int unsigned X_W        = 43;
  localparam int unsigned T_W        = 31;
  localparam int unsigned R30_W      = 30;
  localparam int unsigned N_W        = 5;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SQRT_LAT     = D_W;
  localparam int unsigned HORNER_TERMS = 12;
  localparam int unsigned EXP_LAT      = 2 * HORNER_TERMS + 3;
  localparam int unsigned DIV_LAT      = OUT_W;
  localparam int unsigned FRONT_LAT    = 8;
  localparam int unsigned EXP_NMAX     = 30;

  localparam logic [DIFF_W-1:0] DIFF_CLAMP = DIFF_W'(64'd33554432);
  localparam logic [S_W-1:0]    S_MAX      = S_W'(64'd33554431 * 64'd33554431);
  localparam logic [31:0]       PI_E9      = 32'd3140000000;
  localparam logic [GEO_W-1:0]  GEO_CAP    = GEO_W'(64'd1 << 61);
  localparam logic [X_W-1:0]    LN2_Q24    = X_W'(64'd11629080);
  localparam logic [X_W-1:0]    EXP_LIMIT  = X_W'(64'd21 << 24);
  localparam logic [T_W-1:0]    ONE_Q30    = T_W'(64'd1 << 30);
  localparam logic [OUT_W-1:0]  OUT_MAX    = '1;

  localparam logic [COEF_W-1:0] COEF_RST = COEF_W'(2818);
  localparam logic [AREA_W-1:0] RXA_RST  = AREA_W'(1100);
  localparam logic [AREA_W-1:0] TXA_RST  = AREA_W'(10000);
  localparam logic [OMC_W-1:0]  OMC_RST  = OMC_W'(8028);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTEN   = 3'd0,
    REG_RX_AREA = 3'd1,
    REG_TX_AREA = 3'd2,
    REG_OMC     = 3'd3
  } cfg_reg_e;

  localparam int unsigned RECIP_SH [1:12] = '{31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35};

  localparam logic [31:0] RECIP_M [1:12] = '{
    32'(((64'd1 << 31) + 64'd0)  / 64'd1),
    32'(((64'd1 << 32) + 64'd1)  / 64'd2),
    32'(((64'd1 << 33) + 64'd2)  / 64'd3),
    32'(((64'd1 << 33) + 64'd3)  / 64'd4),
    32'(((64'd1 << 34) + 64'd4)  / 64'd5),
    32'(((64'd1 << 34) + 64'd5)  / 64'd6),
    32'(((64'd1 << 34) + 64'd6)  / 64'd7),
    32'(((64'd1 << 34) + 64'd7)  / 64'd8),
    32'(((64'd1 << 35) + 64'd8)  / 64'd9),
    32'(((64'd1 << 35) + 64'd9)  / 64'd10),
    32'(((64'd1 << 35) + 64'd10) / 64'd11),
    32'(((64'd1 << 35) + 64'd11) / 64'd12)
  };

endpackage
`default_nettype wire

@@ sv/optical_link_rx_power.sv @@
// Top level: received optical power over a line-of-sight underwater link.
// Pipeline: 7 front stages, 25 root stages, 27 exponential stages, 1 product stage
// and 32 quotient stages from input beat to result beat.
// Throughput: one beat per cycle unless the output stalls; the one-bit-per-stage
// root and quotient units set the depth. A stalled output holds every stage
// in place. Reset clears the stage valid bits and loads the register defaults.
`default_nettype none
module optical_link_rx_power #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned POWER_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [POWER_WIDTH-1:0]          tx_power_i,
  input  logic signed [COORD_WIDTH-1:0]   tx_x_i,
  input  logic signed [COORD_WIDTH-1:0]   tx_y_i,
  input  logic signed [COORD_WIDTH-1:0]   tx_z_i,
  input  logic signed [COORD_WIDTH-1:0]   rx_x_i,
  input  logic signed [COORD_WIDTH-1:0]   rx_y_i,
  input  logic signed [COORD_WIDTH-1:0]   rx_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [olrp_pkg::OUT_W-1:0]      rx_power_o,
  output logic [olrp_pkg::D_W-1:0]        link_distance_o,
  output logic                            saturated_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [olrp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [olrp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW      = POWER_WIDTH + olrp_pkg::AREA_W;
  localparam int unsigned PROD_W  = AW + olrp_pkg::E_W;
  localparam int unsigned CW1     = COORD_WIDTH + 1;
  localparam int unsigned MAG_W   = (CW1 > olrp_pkg::DIFF_W) ? CW1 : olrp_pkg::DIFF_W;
  localparam int unsigned SIDE1_W = AW + olrp_pkg::DEN_W;
  localparam int unsigned SIDE2_W = SIDE1_W + olrp_pkg::D_W;
  localparam int unsigned LAT     = olrp_pkg::FRONT_LAT + olrp_pkg::SQRT_LAT
                                  + olrp_pkg::EXP_LAT + olrp_pkg::DIV_LAT;
  localparam int unsigned DIFF_W  = olrp_pkg::DIFF_W;
  localparam int unsigned SQ_W    = olrp_pkg::SQ_W;
  localparam int unsigned SUM_W   = olrp_pkg::SUM_W;
  localparam int unsigned S_W     = olrp_pkg::S_W;
  localparam int unsigned M1_W    = olrp_pkg::M1_W;
  localparam int unsigned PP_W    = olrp_pkg::PP_W;
  localparam int unsigned FULL_W  = olrp_pkg::FULL_W;
  localparam int unsigned GEO_W   = olrp_pkg::GEO_W;
  localparam int unsigned DEN_W   = olrp_pkg::DEN_W;
  localparam int unsigned D_W     = olrp_pkg::D_W;
  localparam int unsigned E_W     = olrp_pkg::E_W;

  function automatic logic [DIFF_W-1:0] coord_diff(input logic [COORD_WIDTH-1:0] a,
                                                   input logic [COORD_WIDTH-1:0] b);
    logic signed [COORD_WIDTH:0] dd;
    logic [COORD_WIDTH:0]        ad;
    logic [MAG_W-1:0]            mag;
    dd  = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    ad  = dd[COORD_WIDTH] ? CW1'(-dd) : CW1'(dd);
    mag = MAG_W'(ad);
    if (mag > MAG_W'(olrp_pkg::DIFF_CLAMP)) begin
      return olrp_pkg::DIFF_CLAMP;
    end
    return DIFF_W'(mag);
  endfunction

  logic [olrp_pkg::COEF_W-1:0] coef_q;
  logic [olrp_pkg::AREA_W-1:0] rx_area_q;
  logic [olrp_pkg::AREA_W-1:0] tx_area_q;
  logic [olrp_pkg::OMC_W-1:0]  omc_q;

  logic           adv;
  logic [LAT-1:0] vld_q;

  logic [DIFF_W-1:0]      dx_q, dy_q, dz_q;
  logic [POWER_WIDTH-1:0] p_q;
  logic [SQ_W-1:0]        sqx_q, sqy_q, sqz_q;
  logic [AW-1:0]          a2_q, a3_q, a4_q, a5_q, a6_q, a7_q;
  logic [SUM_W-1:0]       sum_d;
  logic [S_W-1:0]         s3_q, s4_q, s5_q, s6_q, s7_q;
  logic [M1_W-1:0]        m1_q;
  logic [PP_W-1:0]        pl_q, ph_q;
  logic [FULL_W-1:0]      full_d;
  logic [M1_W-1:0]        geo_full_d;
  logic [GEO_W-1:0]       geo_q;
  logic [DEN_W-1:0]       den_q;

  logic [D_W-1:0]     d_sq;
  logic [SIDE1_W-1:0] side_sq;
  logic [E_W-1:0]     e_ex;
  logic [SIDE2_W-1:0] side_ex;
  logic [AW-1:0]      a_ex;
  logic [DEN_W-1:0]   den_ex;
  logic [D_W-1:0]     d_ex;

  logic [PROD_W-1:0]  prod_q;
  logic [DEN_W-1:0]   den_p_q;
  logic [D_W-1:0]     d_p_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q    <= olrp_pkg::COEF_RST;
      rx_area_q <= olrp_pkg::RXA_RST;
      tx_area_q <= olrp_pkg::TXA_RST;
      omc_q     <= olrp_pkg::OMC_RST;
    end else if (cfg_valid_i) begin
      unique case (olrp_pkg::cfg_reg_e'(cfg_index_i))
        olrp_pkg::REG_ATTEN:   coef_q    <= cfg_data_i[olrp_pkg::COEF_W-1:0];
        olrp_pkg::REG_RX_AREA: rx_area_q <= cfg_data_i[olrp_pkg::AREA_W-1:0];
        olrp_pkg::REG_TX_AREA: tx_area_q <= cfg_data_i[olrp_pkg::AREA_W-1:0];
        olrp_pkg::REG_OMC:     omc_q     <= cfg_data_i[olrp_pkg::OMC_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign sum_d      = SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
  assign full_d     = (FULL_W'(ph_q) << 33) + FULL_W'(pl_q);
  assign geo_full_d = full_d[FULL_W-1:32];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= coord_diff(tx_x_i, rx_x_i);
      dy_q  <= coord_diff(tx_y_i, rx_y_i);
      dz_q  <= coord_diff(tx_z_i, rx_z_i);
      p_q   <= tx_power_i;

      sqx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
      sqy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
      sqz_q <= SQ_W'(dz_q) * SQ_W'(dz_q);
      a2_q  <= AW'(p_q) * AW'(rx_area_q);

      s3_q  <= (sum_d > SUM_W'(olrp_pkg::S_MAX)) ? olrp_pkg::S_MAX : S_W'(sum_d);
      a3_q  <= a2_q;

      m1_q  <= M1_W'(s3_q) * M1_W'(omc_q);
      s4_q  <= s3_q;
      a4_q  <= a3_q;

      pl_q  <= PP_W'(m1_q[32:0]) * PP_W'(olrp_pkg::PI_E9);
      ph_q  <= PP_W'(m1_q[M1_W-1:33]) * PP_W'(olrp_pkg::PI_E9);
      s5_q  <= s4_q;
      a5_q  <= a4_q;

      geo_q <= (geo_full_d >= M1_W'(olrp_pkg::GEO_CAP)) ? olrp_pkg::GEO_CAP
                                                         : GEO_W'(geo_full_d);
      s6_q  <= s5_q;
      a6_q  <= a5_q;

      den_q <= DEN_W'(geo_q) + DEN_W'({tx_area_q, 1'b0});
      s7_q  <= s6_q;
      a7_q  <= a6_q;
    end
  end

  olrp_sqrt #(
    .SIDE_W (SIDE1_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .s_i    (s7_q),
    .side_i ({a7_q, den_q}),
    .d_o    (d_sq),
    .side_o (side_sq)
  );

  olrp_exp #(
    .SIDE_W (SIDE2_W)
  ) u_exp (
    .clk_i  (clk_i),
    .en_i   (adv),
    .coef_i (coef_q),
    .d_i    (d_sq),
    .side_i ({side_sq, d_sq}),
    .e_o    (e_ex),
    .side_o (side_ex)
  );

  assign {a_ex, den_ex, d_ex} = side_ex;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= PROD_W'(a_ex) * PROD_W'(e_ex);
      den_p_q <= den_ex;
      d_p_q   <= d_ex;
    end
  end

  olrp_div #(
    .PROD_W (PROD_W),
    .SIDE_W (D_W)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .prod_i (prod_q),
    .den_i  (den_p_q),
    .side_i (d_p_q),
    .pw_o   (rx_power_o),
    .sat_o  (saturated_o),
    .side_o (link_distance_o)
  );

  assign out_valid_o = vld_q[LAT-1];

endmodule
`default_nettype wire

@@ sv/olrp_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module olrp_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [olrp_pkg::S_W-1:0]   s_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic [olrp_pkg::D_W-1:0]   d_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned N   = olrp_pkg::SQRT_LAT;
  localparam int unsigned SW  = olrp_pkg::S_W;
  localparam int unsigned DW  = olrp_pkg::D_W;
  localparam int unsigned TW  = SW + 2;

  logic [DW-1:0]     r_q    [N];
  logic [SW-1:0]     sq_q   [N];
  logic [SW-1:0]     s_q    [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int unsigned B = N - 1 - i;
    logic [DW-1:0]     r_in;
    logic [SW-1:0]     sq_in;
    logic [SW-1:0]     s_in;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     trial;

    if (i == 0) begin : g_head
      assign r_in    = '0;
      assign sq_in   = '0;
      assign s_in    = s_i;
      assign side_in = side_i;
    end else begin : g_body
      assign r_in    = r_q[i-1];
      assign sq_in   = sq_q[i-1];
      assign s_in    = s_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = TW'(sq_in) + (TW'(r_in) << (B + 1)) + (TW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial <= TW'(s_in)) begin
          r_q[i]  <= r_in | (DW'(1) << B);
          sq_q[i] <= SW'(trial);
        end else begin
          r_q[i]  <= r_in;
          sq_q[i] <= sq_in;
        end
        s_q[i]    <= s_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign d_o    = r_q[N-1];
  assign side_o = side_q[N-1];

endmodule
`default_nettype wire

@@ sv/olrp_exp.sv @@
// Pipelined exp(-c*d): range reduction by ln2, then a Horner series over stage pairs.
`default_nettype none
module olrp_exp #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [olrp_pkg::COEF_W-1:0] coef_i,
  input  logic [olrp_pkg::D_W-1:0]    d_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [olrp_pkg::E_W-1:0]    e_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned XW  = olrp_pkg::X_W;
  localparam int unsigned TW  = olrp_pkg::T_W;
  localparam int unsigned RW  = olrp_pkg::R30_W;
  localparam int unsigned NW  = olrp_pkg::N_W;
  localparam int unsigned EW  = olrp_pkg::E_W;
  localparam int unsigned NH  = 2 * olrp_pkg::HORNER_TERMS;
  localparam int unsigned AMW = RW + TW;
  localparam int unsigned BMW = TW + 32;

  logic [XW-1:0]     x_q;
  logic [SIDE_W-1:0] side0_q;

  logic [NW-1:0]     n_d;
  logic [XW-1:0]     rem_d;
  logic [NW-1:0]     n1_q;
  logic [RW-1:0]     r1_q;
  logic              z1_q;
  logic [SIDE_W-1:0] side1_q;

  logic [TW-1:0]     acc_q  [NH];
  logic [RW-1:0]     r_q    [NH];
  logic [NW-1:0]     n_q    [NH];
  logic              z_q    [NH];
  logic [SIDE_W-1:0] side_q [NH];

  logic [EW-1:0]     e_q;
  logic [SIDE_W-1:0] sidee_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= XW'(coef_i) * XW'(d_i);
      side0_q <= side_i;
    end
  end

  always_comb begin
    n_d = '0;
    for (int k = 1; k <= int'(olrp_pkg::EXP_NMAX); k++) begin
      if (x_q >= XW'(k) * olrp_pkg::LN2_Q24) begin
        n_d = NW'(k);
      end
    end
    rem_d = x_q - XW'(n_d) * olrp_pkg::LN2_Q24;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q    <= n_d;
      r1_q    <= {rem_d[RW-7:0], 6'b0};
      z1_q    <= (x_q >= olrp_pkg::EXP_LIMIT);
      side1_q <= side0_q;
    end
  end

  for (genvar j = 0; j < NH; j++) begin : g_step
    localparam int unsigned K = olrp_pkg::HORNER_TERMS - j / 2;
    logic [TW-1:0]     acc_in;
    logic [RW-1:0]     r_in;
    logic [NW-1:0]     n_in;
    logic              z_in;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     acc_next;

    if (j == 0) begin : g_head
      assign acc_in  = olrp_pkg::ONE_Q30;
      assign r_in    = r1_q;
      assign n_in    = n1_q;
      assign z_in    = z1_q;
      assign side_in = side1_q;
    end else begin : g_body
      assign acc_in  = acc_q[j-1];
      assign r_in    = r_q[j-1];
      assign n_in    = n_q[j-1];
      assign z_in    = z_q[j-1];
      assign side_in = side_q[j-1];
    end

    if (j % 2 == 0) begin : g_mul
      logic [AMW-1:0] prod;
      assign prod     = AMW'(r_in) * AMW'(acc_in);
      assign acc_next = TW'(prod >> 30);
    end else begin : g_div
      logic [BMW-1:0] prod;
      assign prod     = BMW'(acc_in) * BMW'(olrp_pkg::RECIP_M[K]);
      assign acc_next = olrp_pkg::ONE_Q30 - TW'(prod >> olrp_pkg::RECIP_SH[K]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j]  <= acc_next;
        r_q[j]    <= r_in;
        n_q[j]    <= n_in;
        z_q[j]    <= z_in;
        side_q[j] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_q[NH-1]) begin
        e_q <= '0;
      end else begin
        e_q <= EW'(acc_q[NH-1] >> ({1'b0, n_q[NH-1]} + 6'd10));
      end
      sidee_q <= side_q[NH-1];
    end
  end

  assign e_o    = e_q;
  assign side_o = sidee_q;

endmodule
`default_nettype wire

@@ sv/olrp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with saturation.
`default_nettype none
module olrp_div #(
  parameter int unsigned PROD_W = 65,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [PROD_W-1:0]          prod_i,
  input  logic [olrp_pkg::DEN_W-1:0] den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic [olrp_pkg::OUT_W-1:0] pw_o,
  output logic                       sat_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned N   = olrp_pkg::DIV_LAT;
  localparam int unsigned QW  = olrp_pkg::OUT_W;
  localparam int unsigned DNW = olrp_pkg::DEN_W;
  localparam int unsigned XW  = PROD_W - 11;

  logic [XW-1:0]     x_in;
  logic [DNW-1:0]    den_q  [N];
  logic [DNW-1:0]    rem_q  [N];
  logic [QW-1:0]     xl_q   [N];
  logic [QW-1:0]     q_q    [N];
  logic              sat_q  [N];
  logic              zero_q [N];
  logic [SIDE_W-1:0] side_q [N];

  assign x_in = prod_i[PROD_W-1:11];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int unsigned B = N - 1 - i;
    logic [DNW-1:0]    den_in;
    logic [DNW-1:0]    rem_in;
    logic [QW-1:0]     xl_in;
    logic [QW-1:0]     q_in;
    logic              sat_in;
    logic              zero_in;
    logic [SIDE_W-1:0] side_in;
    logic [DNW:0]      rem2;
    logic              ge;
    logic [QW-1:0]     q_next;

    if (i == 0) begin : g_head
      assign den_in  = den_i;
      assign rem_in  = DNW'(x_in[XW-1:QW]);
      assign xl_in   = x_in[QW-1:0];
      assign q_in    = '0;
      assign zero_in = (prod_i == '0);
      assign sat_in  = (DNW'(x_in[XW-1:QW]) >= den_i) && !zero_in;
      assign side_in = side_i;
    end else begin : g_body
      assign den_in  = den_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign xl_in   = xl_q[i-1];
      assign q_in    = q_q[i-1];
      assign sat_in  = sat_q[i-1];
      assign zero_in = zero_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem2   = {rem_in, xl_in[B]};
    assign ge     = (rem2 >= {1'b0, den_in});
    assign q_next = q_in | (QW'(ge) << B);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[i]  <= den_in;
        rem_q[i]  <= ge ? DNW'(rem2 - {1'b0, den_in}) : DNW'(rem2);
        xl_q[i]   <= xl_in;
        sat_q[i]  <= sat_in;
        zero_q[i] <= zero_in;
        side_q[i] <= side_in;
        if (i == N - 1) begin
          q_q[i] <= sat_in ? olrp_pkg::OUT_MAX : (zero_in ? '0 : q_next);
        end else begin
          q_q[i] <= q_next;
        end
      end
    end
  end

  assign pw_o   = q_q[N-1];
  assign sat_o  = sat_q[N-1];
  assign side_o = side_q[N-1];

endmodule
`default_nettype wire

@@ sv/olrp_checker.sv @@
// Port-level checks for the rx power block and their bind to the top level.
`default_nettype none
module olrp_sva #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned POWER_WIDTH = 24
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [POWER_WIDTH-1:0]          tx_power_i,
  input logic [COORD_WIDTH-1:0]          tx_x_i,
  input logic [COORD_WIDTH-1:0]          tx_y_i,
  input logic [COORD_WIDTH-1:0]          tx_z_i,
  input logic [COORD_WIDTH-1:0]          rx_x_i,
  input logic [COORD_WIDTH-1:0]          rx_y_i,
  input logic [COORD_WIDTH-1:0]          rx_z_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [olrp_pkg::OUT_W-1:0]      rx_power_o,
  input logic [olrp_pkg::D_W-1:0]        link_distance_o,
  input logic                            saturated_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [olrp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [olrp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_power_o)
      && $stable(link_distance_o) && $stable(saturated_o))
    else $error("result beat changed while stalled");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> rx_power_o == olrp_pkg::OUT_MAX)
    else $error("saturated beat without full-scale power");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind optical_link_rx_power olrp_sva #(
  .COORD_WIDTH (COORD_WIDTH),
  .POWER_WIDTH (POWER_WIDTH)
) u_olrp_sva (.*);
`default_nettype wire
